/* hdl/rbdt_pkg.sv */
// Package for the retry backoff deadline timer.
// Holds field widths, command/status/register codes and shared structs.
// No dependencies.
package rbdt_pkg;

    localparam int TimeW    = 32;
    localparam int DelayW   = 31;
    localparam int ModeW    = 2;
    localparam int StatusW  = 2;
    localparam int CountW   = 2;
    localparam int CfgIdxW  = 2;
    localparam int InDataW  = 32;
    localparam int OutDataW = 40;

    localparam logic [ModeW-1:0] MODE_POLL     = 2'd0;
    localparam logic [ModeW-1:0] MODE_SCHEDULE = 2'd1;
    localparam logic [ModeW-1:0] MODE_RESET    = 2'd2;

    localparam logic [StatusW-1:0] ST_OK        = 2'd0;
    localparam logic [StatusW-1:0] ST_ARMED     = 2'd1;
    localparam logic [StatusW-1:0] ST_NO_DELAY  = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_FIRST  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SECOND = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_THIRD  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_LIMIT  = 2'd3;

    localparam logic [CountW-1:0] MAX_ATTEMPTS = 2'd3;

    localparam logic [DelayW-1:0] FIRST_RST  = 31'd1000;
    localparam logic [DelayW-1:0] SECOND_RST = 31'd2000;
    localparam logic [DelayW-1:0] THIRD_RST  = 31'd4000;
    localparam logic [CountW-1:0] LIMIT_RST  = 2'd3;

    typedef struct packed {
        logic [CountW-1:0] attempt_limit;
        logic [DelayW-1:0] third_delay;
        logic [DelayW-1:0] second_delay;
        logic [DelayW-1:0] first_delay;
    } cfg_t;

    // packed MSB first: status lands in the lowest bits
    typedef struct packed {
        logic              is_armed;
        logic [CountW-1:0] attempt_count;
        logic              exhausted;
        logic              due_now;
        logic              fired;
        logic [DelayW-1:0] chosen_delay;
        logic [StatusW-1:0] status;
    } result_t;

endpackage

/* hdl/retry_backoff_deadline_timer.sv */
// Retry backoff deadline timer, top level.
// Result words are registered before they appear on m_tvalid.
// Throughput: one word per cycle while s_tready is high; state updates at each accept.
// Output register plus one skid entry keep s_tready up while a result waits.
// aresetn (sync, active low) clears state, output valids and restores delay defaults.
// Depends on rbdt_pkg, rbdt_cfg, rbdt_core, rbdt_skid.
module retry_backoff_deadline_timer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rbdt_pkg::InDataW-1:0]      s_tdata,   // now_ms[31:0]
    input  logic [rbdt_pkg::ModeW-1:0]        s_tuser,   // mode[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], delay[32:2], fired[33], due_now[34], exhausted[35],
    // attempt_count[37:36], is_armed[38], zero[39]
    output logic [rbdt_pkg::OutDataW-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbdt_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [rbdt_pkg::DelayW-1:0]       cfg_data
);

    rbdt_pkg::cfg_t    cfg;
    rbdt_pkg::result_t core_result;
    rbdt_pkg::result_t out_result;
    logic              in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;

    rbdt_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rbdt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .mode    (s_tuser),
        .now_ms  (s_tdata),
        .cfg     (cfg),
        .result  (core_result)
    );

    rbdt_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_fire),
        .in_data   (core_result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_result),
        .out_ready (m_tready)
    );

    assign m_tdata = {1'b0, out_result};

endmodule

/* hdl/rbdt_cfg.sv */
// Configuration register file for the retry timer.
// Depends on rbdt_pkg.
module rbdt_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [rbdt_pkg::CfgIdxW-1:0]   wr_index,
    input  logic [rbdt_pkg::DelayW-1:0]    wr_data,
    output rbdt_pkg::cfg_t                 cfg
);

    rbdt_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                rbdt_pkg::REG_FIRST:  cfg_next.first_delay   = wr_data;
                rbdt_pkg::REG_SECOND: cfg_next.second_delay  = wr_data;
                rbdt_pkg::REG_THIRD:  cfg_next.third_delay   = wr_data;
                rbdt_pkg::REG_LIMIT:  cfg_next.attempt_limit = wr_data[rbdt_pkg::CountW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_delay   <= rbdt_pkg::FIRST_RST;
            cfg_reg.second_delay  <= rbdt_pkg::SECOND_RST;
            cfg_reg.third_delay   <= rbdt_pkg::THIRD_RST;
            cfg_reg.attempt_limit <= rbdt_pkg::LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/rbdt_core.sv */
// Timer state and per-command update logic; produces one result per word.
// Depends on rbdt_pkg.
module rbdt_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_fire,
    input  logic [rbdt_pkg::ModeW-1:0]   mode,
    input  logic [rbdt_pkg::TimeW-1:0]   now_ms,
    input  rbdt_pkg::cfg_t               cfg,
    output rbdt_pkg::result_t            result
);

    logic [rbdt_pkg::TimeW-1:0]  deadline_reg, deadline_next;
    logic [rbdt_pkg::CountW-1:0] attempts_reg, attempts_next;
    logic                        armed_reg, armed_next;

    logic [rbdt_pkg::TimeW-1:0]  elapsed_old;
    logic [rbdt_pkg::TimeW-1:0]  elapsed_new;
    logic [rbdt_pkg::DelayW-1:0] sel_delay;
    logic                        reached_old;

    assign elapsed_old = now_ms - deadline_reg;
    assign reached_old = armed_reg && !elapsed_old[rbdt_pkg::TimeW-1];

    always_comb begin
        case (attempts_reg)
            2'd0:    sel_delay = cfg.first_delay;
            2'd1:    sel_delay = cfg.second_delay;
            default: sel_delay = cfg.third_delay;
        endcase
    end

    always_comb begin
        deadline_next = deadline_reg;
        attempts_next = attempts_reg;
        armed_next    = armed_reg;
        result.status       = rbdt_pkg::ST_OK;
        result.chosen_delay = '0;
        result.fired        = 1'b0;
        unique case (mode)
            rbdt_pkg::MODE_POLL: begin
                if (reached_old) begin
                    armed_next   = 1'b0;
                    result.fired = 1'b1;
                end
            end
            rbdt_pkg::MODE_SCHEDULE: begin
                if (armed_reg) begin
                    result.status = rbdt_pkg::ST_ARMED;
                end else if (attempts_reg == rbdt_pkg::MAX_ATTEMPTS) begin
                    result.status = rbdt_pkg::ST_NO_DELAY;
                end else begin
                    result.chosen_delay = sel_delay;
                    deadline_next       = now_ms + {1'b0, sel_delay};
                    attempts_next       = attempts_reg + 2'd1;
                    armed_next          = 1'b1;
                end
            end
            rbdt_pkg::MODE_RESET: begin
                deadline_next = '0;
                attempts_next = '0;
                armed_next    = 1'b0;
            end
            default: ;
        endcase
        elapsed_new          = now_ms - deadline_next;
        result.due_now       = armed_next && !elapsed_new[rbdt_pkg::TimeW-1];
        result.exhausted     = (attempts_next >= cfg.attempt_limit);
        result.attempt_count = attempts_next;
        result.is_armed      = armed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadline_reg <= '0;
            attempts_reg <= '0;
            armed_reg    <= 1'b0;
        end else if (in_fire) begin
            deadline_reg <= deadline_next;
            attempts_reg <= attempts_next;
            armed_reg    <= armed_next;
        end
    end

endmodule

/* hdl/rbdt_skid.sv */
// Output register with one skid entry for result words.
// Depends on rbdt_pkg.
module rbdt_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  rbdt_pkg::result_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    output rbdt_pkg::result_t out_data,
    input  logic              out_ready
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    rbdt_pkg::result_t out_data_reg, out_data_next;
    rbdt_pkg::result_t skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
